// ===== src/eav_pkg.sv =====
// ---------------------------------------------------------------------------
// eav_pkg
// Shared widths, codes, controller states and the command and status
// bundles of the accelerated encoder value block.
// ---------------------------------------------------------------------------
package eav_pkg;

    // saturation width of the running sum
    localparam int VALUE_WIDTH = 32;

    localparam int DATA_W    = 32;              // value, position, limits
    localparam int STEP_W    = 31;              // step size
    localparam int RATIO_W   = 8;
    localparam int GAP_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int MUL_A_W   = 16;              // narrow multiplier operand
    localparam int MUL_P_W   = MUL_A_W + STEP_W;
    localparam int CAP_W     = MUL_P_W + 1;
    localparam int MAG_W     = DATA_W + STEP_W; // |delta| * step
    localparam int PROD_W    = MAG_W + 1;       // signed product
    localparam int SUM_W     = PROD_W + 1;      // value plus product
    localparam int DIV_STEPS = STEP_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);
    localparam int M_DATA_W  = 64;

    localparam logic signed [SUM_W-1:0] SAT_HI =
        {{(SUM_W-VALUE_WIDTH+1){1'b0}}, {(VALUE_WIDTH-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SAT_LO = ~SAT_HI;

    localparam logic signed [DATA_W-1:0] MIN_VALUE_RST   = '0;
    localparam logic signed [DATA_W-1:0] MAX_VALUE_RST   = DATA_W'(10000);
    localparam logic [RATIO_W-1:0]       ACCEL_RATIO_RST = RATIO_W'(5);
    localparam logic [GAP_W-1:0]         ACCEL_GAP_RST   = GAP_W'(10);
    localparam logic [RATIO_W-1:0]       RATIO_MIN_DIV   = RATIO_W'(2);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MIN_VALUE,
        REG_MAX_VALUE,
        REG_ACCEL_RATIO,
        REG_ACCEL_GAP
    } cfg_reg_t;

    typedef enum logic {
        OP_POSITION,
        OP_TICK
    } opcode_t;

    typedef enum logic [1:0] {
        MUL_DIFF_LO,
        MUL_DIFF_HI,
        MUL_GAP,
        MUL_RATIO
    } mul_sel_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_POS_DIFF,
        ST_POS_MUL_LO,
        ST_POS_MUL_HI,
        ST_POS_ACC,
        ST_POS_SIGN,
        ST_POS_SUM,
        ST_POS_CLAMP,
        ST_TICK_MOVE,
        ST_TICK_GAP,
        ST_TICK_CAP,
        ST_TICK_LOW,
        ST_DIV,
        ST_DIV_END,
        ST_TICK_END,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic     load_in;
        logic     load_diff;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     acc_lo;
        logic     acc_hi;
        logic     sign;
        logic     sum;
        logic     clamp;
        logic     move;
        logic     cap;
        logic     div_init;
        logic     div_step;
        logic     div_end;
        logic     tick_end;
        logic     load_out;
    } eav_cmd_t;

    typedef struct packed {
        logic same_pos;
        logic gap_exceeded;
        logic below_step;
        logic ratio_div;
        logic out_free;
    } eav_status_t;

endpackage

// ===== src/eav_ctrl.sv =====
// ---------------------------------------------------------------------------
// eav_ctrl
// Sequencer for one item: position update or tick step adaptation, with a
// bit-serial division count, then hand-off to the output register.
// ---------------------------------------------------------------------------
module eav_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic                 s_tuser,
    input  eav_pkg::eav_status_t status,
    output eav_pkg::eav_cmd_t    cmd
);
    import eav_pkg::*;

    state_t               state_reg, state_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    state_next  = (opcode_t'(s_tuser) == OP_TICK) ? ST_TICK_MOVE
                                                                   : ST_POS_DIFF;
                end
            end
            ST_POS_DIFF: begin
                cmd.load_diff = 1'b1;
                state_next    = status.same_pos ? ST_OUT : ST_POS_MUL_LO;
            end
            ST_POS_MUL_LO: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_DIFF_LO;
                state_next  = ST_POS_MUL_HI;
            end
            ST_POS_MUL_HI: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_DIFF_HI;
                cmd.acc_lo  = 1'b1;
                state_next  = ST_POS_ACC;
            end
            ST_POS_ACC: begin
                cmd.acc_hi = 1'b1;
                state_next = ST_POS_SIGN;
            end
            ST_POS_SIGN: begin
                cmd.sign   = 1'b1;
                state_next = ST_POS_SUM;
            end
            ST_POS_SUM: begin
                cmd.sum    = 1'b1;
                state_next = ST_POS_CLAMP;
            end
            ST_POS_CLAMP: begin
                cmd.clamp  = 1'b1;
                state_next = ST_OUT;
            end
            ST_TICK_MOVE: begin
                cmd.move    = 1'b1;
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_GAP;
                state_next  = ST_TICK_GAP;
            end
            ST_TICK_GAP: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_RATIO;
                state_next  = status.gap_exceeded ? ST_TICK_CAP : ST_TICK_LOW;
            end
            ST_TICK_CAP: begin
                cmd.cap    = 1'b1;
                state_next = ST_TICK_LOW;
            end
            ST_TICK_LOW: begin
                if (status.below_step && status.ratio_div) begin
                    cmd.div_init = 1'b1;
                    cnt_next     = DIV_CNT_W'(DIV_STEPS - 1);
                    state_next   = ST_DIV;
                end else begin
                    state_next = ST_TICK_END;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (cnt_reg == '0) begin
                    state_next = ST_DIV_END;
                end else begin
                    cnt_next = cnt_reg - DIV_CNT_W'(1);
                end
            end
            ST_DIV_END: begin
                cmd.div_end = 1'b1;
                state_next  = ST_TICK_END;
            end
            ST_TICK_END: begin
                cmd.tick_end = 1'b1;
                state_next   = ST_OUT;
            end
            ST_OUT: begin
                if (status.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== src/eav_dp.sv =====
// ---------------------------------------------------------------------------
// eav_dp
// Datapath: settings registers, encoder state, shared 16 x 31 multiplier,
// saturate and clamp, serial divider and the output register.
// ---------------------------------------------------------------------------
module eav_dp (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    input  logic [eav_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [eav_pkg::DATA_W-1:0]    cfg_data,
    input  logic [eav_pkg::DATA_W-1:0]    s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [eav_pkg::M_DATA_W-1:0]  m_tdata,
    output logic                          m_tuser,
    input  eav_pkg::eav_cmd_t             cmd,
    output eav_pkg::eav_status_t          status
);
    import eav_pkg::*;

    // settings
    logic signed [DATA_W-1:0] min_reg, min_next;
    logic signed [DATA_W-1:0] max_reg, max_next;
    logic [RATIO_W-1:0]       ratio_reg, ratio_next;
    logic [GAP_W-1:0]         gap_reg, gap_next;

    // encoder state
    logic signed [DATA_W-1:0] last_pos_reg, last_pos_next;
    logic signed [DATA_W-1:0] acc_reg, acc_next;
    logic [STEP_W-1:0]        step_reg, step_next;
    logic signed [DATA_W-1:0] vac_reg, vac_next;
    logic signed [DATA_W-1:0] vat_reg, vat_next;
    logic                     m_tvalid_reg, m_tvalid_next;

    // working registers
    logic signed [DATA_W-1:0] pos_reg, pos_next;
    logic                     neg_reg, neg_next;
    logic [DATA_W-1:0]        dmag_reg, dmag_next;
    logic [MUL_P_W-1:0]       prod_reg, prod_next;
    logic [MAG_W-1:0]         mag_reg, mag_next;
    logic signed [PROD_W-1:0] sprod_reg, sprod_next;
    logic signed [SUM_W-1:0]  sat_reg, sat_next;
    logic [DATA_W-1:0]        moved_reg, moved_next;
    logic [RATIO_W-1:0]       rem_reg, rem_next;
    logic [STEP_W-1:0]        quo_reg, quo_next;
    logic                     clamped_reg, clamped_next;
    logic [M_DATA_W-1:0]      out_data_reg, out_data_next;
    logic                     out_user_reg, out_user_next;

    // combinational intermediates
    logic                     diff_neg;
    logic [MUL_A_W-1:0]       mul_a;
    logic signed [SUM_W-1:0]  sum_wide, min_ext, max_ext, lo_val, final_val;
    logic                     lo_hit, hi_hit;
    logic signed [CAP_W-1:0]  cap_prod, cap_max, cap_val;
    logic [RATIO_W:0]         div_trial;
    logic                     div_bit;

    assign diff_neg = pos_reg < last_pos_reg;
    assign min_ext  = {{(SUM_W-DATA_W){min_reg[DATA_W-1]}}, min_reg};
    assign max_ext  = {{(SUM_W-DATA_W){max_reg[DATA_W-1]}}, max_reg};
    assign lo_hit   = sat_reg < min_ext;
    assign lo_val   = lo_hit ? min_ext : sat_reg;
    assign hi_hit   = lo_val > max_ext;
    assign final_val = hi_hit ? max_ext : lo_val;
    assign sum_wide = {{(SUM_W-DATA_W){acc_reg[DATA_W-1]}}, acc_reg}
                    + {sprod_reg[PROD_W-1], sprod_reg};
    assign cap_prod = {1'b0, prod_reg};
    assign cap_max  = {{(CAP_W-DATA_W){max_reg[DATA_W-1]}}, max_reg};
    assign cap_val  = (cap_prod > cap_max) ? cap_max : cap_prod;
    assign div_trial = {rem_reg, quo_reg[STEP_W-1]} - {1'b0, ratio_reg};
    assign div_bit   = !div_trial[RATIO_W];

    always_comb begin
        case (cmd.mul_sel)
            MUL_DIFF_LO: mul_a = dmag_reg[MUL_A_W-1:0];
            MUL_DIFF_HI: mul_a = dmag_reg[DATA_W-1:MUL_A_W];
            MUL_GAP:     mul_a = gap_reg;
            MUL_RATIO:   mul_a = MUL_A_W'(ratio_reg);
            default:     mul_a = '0;
        endcase
    end

    assign status.same_pos     = pos_reg == last_pos_reg;
    assign status.gap_exceeded = MUL_P_W'(moved_reg) > prod_reg;
    assign status.below_step   = moved_reg < DATA_W'(step_reg);
    assign status.ratio_div    = ratio_reg >= RATIO_MIN_DIV;
    assign status.out_free     = !m_tvalid_reg || m_tready;

    always_comb begin
        min_next      = min_reg;
        max_next      = max_reg;
        ratio_next    = ratio_reg;
        gap_next      = gap_reg;
        last_pos_next = last_pos_reg;
        acc_next      = acc_reg;
        step_next     = step_reg;
        vac_next      = vac_reg;
        vat_next      = vat_reg;
        pos_next      = pos_reg;
        neg_next      = neg_reg;
        dmag_next     = dmag_reg;
        prod_next     = prod_reg;
        mag_next      = mag_reg;
        sprod_next    = sprod_reg;
        sat_next      = sat_reg;
        moved_next    = moved_reg;
        rem_next      = rem_reg;
        quo_next      = quo_reg;
        clamped_next  = clamped_reg;
        out_data_next = out_data_reg;
        out_user_next = out_user_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;

        if (cfg_valid) begin
            case (cfg_reg_t'(cfg_index))
                REG_MIN_VALUE:   min_next   = cfg_data;
                REG_MAX_VALUE:   max_next   = cfg_data;
                REG_ACCEL_RATIO: ratio_next = cfg_data[RATIO_W-1:0];
                REG_ACCEL_GAP:   gap_next   = cfg_data[GAP_W-1:0];
                default:         min_next   = min_reg;
            endcase
        end

        if (cmd.load_in) begin
            pos_next     = s_tdata;
            clamped_next = 1'b0;
        end
        if (cmd.load_diff) begin
            neg_next  = diff_neg;
            dmag_next = diff_neg ? DATA_W'(last_pos_reg - pos_reg)
                                 : DATA_W'(pos_reg - last_pos_reg);
        end
        if (cmd.mul_en) begin
            prod_next = MUL_P_W'(mul_a) * MUL_P_W'(step_reg);
        end
        if (cmd.acc_lo) begin
            mag_next = MAG_W'(prod_reg);
        end
        if (cmd.acc_hi) begin
            mag_next = mag_reg + {prod_reg, {MUL_A_W{1'b0}}};
        end
        if (cmd.sign) begin
            sprod_next = neg_reg ? -$signed({1'b0, mag_reg}) : $signed({1'b0, mag_reg});
        end
        if (cmd.sum) begin
            if (sum_wide > SAT_HI) begin
                sat_next = SAT_HI;
            end else if (sum_wide < SAT_LO) begin
                sat_next = SAT_LO;
            end else begin
                sat_next = sum_wide;
            end
        end
        if (cmd.clamp) begin
            acc_next      = final_val[DATA_W-1:0];
            vac_next      = final_val[DATA_W-1:0];
            last_pos_next = pos_reg;
            clamped_next  = lo_hit || hi_hit;
            if (lo_hit || hi_hit) begin
                step_next = STEP_W'(1);
            end
        end
        if (cmd.move) begin
            moved_next = (vac_reg >= vat_reg) ? DATA_W'(vac_reg - vat_reg)
                                              : DATA_W'(vat_reg - vac_reg);
        end
        if (cmd.cap) begin
            step_next = (cap_val < CAP_W'(1)) ? STEP_W'(1) : cap_val[STEP_W-1:0];
        end
        if (cmd.div_init) begin
            rem_next = '0;
            quo_next = step_reg;
        end
        if (cmd.div_step) begin
            rem_next = div_bit ? div_trial[RATIO_W-1:0]
                               : {rem_reg[RATIO_W-2:0], quo_reg[STEP_W-1]};
            quo_next = {quo_reg[STEP_W-2:0], div_bit};
        end
        if (cmd.div_end) begin
            step_next = (quo_reg == '0) ? STEP_W'(1) : quo_reg;
        end
        if (cmd.tick_end) begin
            vat_next = vac_reg;
        end
        if (cmd.load_out) begin
            m_tvalid_next = 1'b1;
            out_data_next = {1'b0, step_reg, acc_reg};
            out_user_next = clamped_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_reg      <= MIN_VALUE_RST;
            max_reg      <= MAX_VALUE_RST;
            ratio_reg    <= ACCEL_RATIO_RST;
            gap_reg      <= ACCEL_GAP_RST;
            last_pos_reg <= '1;
            acc_reg      <= '0;
            step_reg     <= STEP_W'(1);
            vac_reg      <= '1;
            vat_reg      <= '1;
            m_tvalid_reg <= 1'b0;
        end else begin
            min_reg      <= min_next;
            max_reg      <= max_next;
            ratio_reg    <= ratio_next;
            gap_reg      <= gap_next;
            last_pos_reg <= last_pos_next;
            acc_reg      <= acc_next;
            step_reg     <= step_next;
            vac_reg      <= vac_next;
            vat_reg      <= vat_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg      <= pos_next;
        neg_reg      <= neg_next;
        dmag_reg     <= dmag_next;
        prod_reg     <= prod_next;
        mag_reg      <= mag_next;
        sprod_reg    <= sprod_next;
        sat_reg      <= sat_next;
        moved_reg    <= moved_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        clamped_reg  <= clamped_next;
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

`ifndef ASSERT_OFF
    // step size never drops to zero
    a_step_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        step_reg != '0)
        else $error("step size reached zero");

    // a clamped position leaves the step at one
    a_clamp_step: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.clamp |=> (!clamped_reg || step_reg == STEP_W'(1)))
        else $error("clamp did not reset the step");

    // slowing down never grows the step
    a_div_shrinks: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_end |=> step_reg <= $past(step_reg))
        else $error("division raised the step");

    // a loaded result is offered on the next cycle
    a_load_out: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |=> m_tvalid)
        else $error("result not offered after load");
`endif

endmodule

// ===== src/encoder_accelerated_value.sv =====
// ---------------------------------------------------------------------------
// encoder_accelerated_value
// One rotary encoder channel whose value moves by detent delta times an
// adaptive step; interval ticks speed the step up or slow it down.
// ---------------------------------------------------------------------------
//  channel  direction  handshake            payload
//  s_       in         s_tvalid / s_tready  s_tdata: position; s_tuser: opcode
//  m_       out        m_tvalid / m_tready  m_tdata: value, step_size; m_tuser: clamped
//  cfg_     in         cfg_valid/cfg_ready  cfg_index, cfg_data (always ready)
//
//  a position item runs through the difference, the two-pass 16 x 31 multiply
//  and the add, saturate and clamp stages before its result; an unchanged
//  count goes from the difference straight to the result
//  a tick item takes its longest path when the step is divided, through
//  the one-bit-per-cycle divider (31 steps)
//  the next item is accepted once the result sits in the output register,
//  even while the downstream side stalls it
//  aresetn is synchronous, active low; it restores the settings defaults and
//  the encoder state directly, no clearing pass
// ---------------------------------------------------------------------------
module encoder_accelerated_value (
    input  logic                          aclk,
    input  logic                          aresetn,
    // settings write channel
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [eav_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [eav_pkg::DATA_W-1:0]    cfg_data,
    // input items
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [eav_pkg::DATA_W-1:0]    s_tdata,  // [31:0] position
    input  logic                          s_tuser,  // [0] opcode
    // result items
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [eav_pkg::M_DATA_W-1:0]  m_tdata,  // [31:0] value, [62:32] step_size, [63] zero
    output logic                          m_tuser   // [0] clamped
);
    import eav_pkg::*;

    eav_cmd_t    cmd;
    eav_status_t status;

    // settings writes are taken at any time
    assign cfg_ready = 1'b1;

    // sequencer: one item at a time
    eav_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .status   (status),
        .cmd      (cmd)
    );

    // arithmetic, state and the output register
    eav_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

// ===== verif/eav_checker.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// eav_checker
// Follows the settings writes, predicts value, step and clamp flag for every
// accepted encoder item and compares them with the result transfers in order.
// ---------------------------------------------------------------------------
module eav_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [eav_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [eav_pkg::DATA_W-1:0]    cfg_data,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [eav_pkg::DATA_W-1:0]    s_tdata,   // [31:0] position
    input  logic                          s_tuser,   // [0] opcode
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [eav_pkg::M_DATA_W-1:0]  m_tdata,   // [31:0] value, [62:32] step_size, [63] zero
    input  logic                          m_tuser,   // [0] clamped
    output int                            pending_results,
    output int                            fail_count
);
    import eav_pkg::*;

    typedef struct {
        logic signed [DATA_W-1:0] value;
        logic [STEP_W-1:0]        step_size;
        logic                     clamped;
    } encoder_reading_t;

    localparam longint SAT_LIMIT = (longint'(1) <<< (VALUE_WIDTH - 1)) - 1;

    encoder_reading_t expected_readings[$];

    // settings copy
    longint lower_limit, upper_limit, ratio, gap;
    // encoder state
    longint last_detent, acc_value, step, value_at_change, value_at_tick;

    initial fail_count = 0;

    task automatic restore_defaults();
        lower_limit     = longint'(MIN_VALUE_RST);
        upper_limit     = longint'(MAX_VALUE_RST);
        ratio           = ACCEL_RATIO_RST;
        gap             = ACCEL_GAP_RST;
        last_detent     = -1;
        acc_value       = 0;
        step            = 1;
        value_at_change = -1;
        value_at_tick   = -1;
    endtask

    task automatic advance_encoder(input opcode_t op, input logic signed [DATA_W-1:0] detent,
                                   output encoder_reading_t reading);
        longint pos;
        longint sum;
        longint moved;
        reading.clamped = 1'b0;
        if (op == OP_POSITION) begin
            pos = longint'(detent);
            if (pos != last_detent) begin
                sum = acc_value + (pos - last_detent) * step;
                if (sum > SAT_LIMIT)
                    sum = SAT_LIMIT;
                if (sum < -SAT_LIMIT - 1)
                    sum = -SAT_LIMIT - 1;
                // lower bound first, so an inverted range ends at the upper one
                if (sum < lower_limit) begin
                    sum             = lower_limit;
                    step            = 1;
                    reading.clamped = 1'b1;
                end
                if (sum > upper_limit) begin
                    sum             = upper_limit;
                    step            = 1;
                    reading.clamped = 1'b1;
                end
                acc_value       = sum;
                last_detent     = pos;
                value_at_change = sum;
            end
        end else begin
            moved = value_at_change - value_at_tick;
            if (moved < 0)
                moved = -moved;
            if (moved > gap * step) begin
                step = step * ratio;
                if (step > upper_limit)
                    step = upper_limit;
                if (step < 1)
                    step = 1;
            end
            if (moved < step) begin
                if (ratio != 0)
                    step = step / ratio;
                if (step < 1)
                    step = 1;
            end
            value_at_tick = value_at_change;
        end
        reading.value     = acc_value[DATA_W-1:0];
        reading.step_size = step[STEP_W-1:0];
    endtask

    task automatic check_field(input string field, input longint want, input longint got);
        if (want != got) begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        end
    endtask

    always @(posedge aclk) begin
        encoder_reading_t want;
        encoder_reading_t got;
        if (!aresetn) begin
            restore_defaults();
            expected_readings.delete();
            pending_results <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.value     = m_tdata[DATA_W-1:0];
                got.step_size = m_tdata[DATA_W+STEP_W-1:DATA_W];
                got.clamped   = m_tuser;
                if (expected_readings.size() == 0) begin
                    fail_count++;
                    $display("%0t: result transfer with none expected, value %0d step %0d",
                             $time, got.value, got.step_size);
                end else begin
                    want = expected_readings.pop_front();
                    check_field("value", longint'(want.value), longint'(got.value));
                    check_field("step_size", longint'(want.step_size),
                                longint'(got.step_size));
                    check_field("clamped", longint'(want.clamped), longint'(got.clamped));
                    check_field("pad bit", 0, longint'(m_tdata[M_DATA_W-1]));
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_reg_t'(cfg_index))
                    REG_MIN_VALUE:   lower_limit = longint'($signed(cfg_data));
                    REG_MAX_VALUE:   upper_limit = longint'($signed(cfg_data));
                    REG_ACCEL_RATIO: ratio       = cfg_data[RATIO_W-1:0];
                    REG_ACCEL_GAP:   gap         = cfg_data[GAP_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                advance_encoder(opcode_t'(s_tuser), s_tdata, want);
                expected_readings.push_back(want);
            end
            pending_results <= expected_readings.size();
        end
    end

endmodule

// ===== verif/tb_encoder_accelerated_value.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_encoder_accelerated_value
// Drives position samples and interval ticks into the accelerated encoder
// value block under several settings and pacing modes; a checker beside the
// block predicts every result and the top reports the verdict.
// ---------------------------------------------------------------------------
module tb_encoder_accelerated_value;
    import eav_pkg::*;

    localparam int WATCHDOG_LIMIT  = 4000;  // idle cycles, far above a divide plus stalls
    localparam int DRAIN_CYCLES    = 50;    // longest tick latency with margin
    localparam int RANDOM_PHASES   = 7;
    localparam int ITEMS_PER_PHASE = 118;

    // block inputs, known from time zero
    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [DATA_W-1:0]     cfg_data  = '0;
    logic                  s_tvalid  = 1'b0;
    logic [DATA_W-1:0]     s_tdata   = '0;  // [31:0] position
    logic                  s_tuser   = 1'b0; // [0] opcode
    logic                  m_tready  = 1'b0;

    // block outputs
    logic                  cfg_ready;
    logic                  s_tready;
    logic                  m_tvalid;
    logic [M_DATA_W-1:0]   m_tdata;         // [31:0] value, [62:32] step_size, [63] zero
    logic                  m_tuser;         // [0] clamped

    int pending_results;
    int fail_count;

    // pacing, in percent of cycles spent idle
    int tx_idle_pct = 26;
    int rx_idle_pct = 82;

    // run statistics for the summary
    int items_sent    = 0;
    int ticks_sent    = 0;
    int settings_used = 0;

    // simulated knob: current detent count and the burst it is turning in
    logic signed [DATA_W-1:0] dial = '0;
    int dial_dir   = 1;
    int dial_speed = 0;
    int burst_left = 0;

    encoder_accelerated_value dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    eav_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .pending_results (pending_results),
        .fail_count      (fail_count)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // downstream side: random stalls at the current receiver rate
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // one input transfer; valid stays high into the next item unless a gap is drawn
    task automatic send_item(input opcode_t op, input logic [DATA_W-1:0] detent);
        s_tuser  <= op;
        s_tdata  <= detent;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
        if (op == OP_TICK)
            ticks_sent++;
        if ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < tx_idle_pct);
        end
    endtask

    // drop valid, then hold off until every predicted result has been seen
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results != 0)
            @(posedge aclk);
    endtask

    task automatic write_setting(input cfg_reg_t idx, input logic [DATA_W-1:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    // all four registers, back to back; only called with the block drained
    task automatic apply_settings(input logic [DATA_W-1:0] lo, input logic [DATA_W-1:0] hi,
                                  input logic [RATIO_W-1:0] ratio,
                                  input logic [GAP_W-1:0] gap);
        write_setting(REG_MIN_VALUE, lo);
        write_setting(REG_MAX_VALUE, hi);
        write_setting(REG_ACCEL_RATIO, DATA_W'(ratio));
        write_setting(REG_ACCEL_GAP, DATA_W'(gap));
        cfg_valid <= 1'b0;
        @(posedge aclk);
        settings_used++;
    endtask

    // bursts of turning at a steady speed with ticks in between, plus some noise
    task automatic run_random(input int count);
        int pick;
        int jitter;
        for (int i = 0; i < count; i++) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(30, 4);
                dial_dir   = $urandom_range(1) ? 1 : -1;
                case ($urandom_range(4))
                    0:       dial_speed = 0;
                    1:       dial_speed = 1;
                    2:       dial_speed = $urandom_range(6, 2);
                    3:       dial_speed = $urandom_range(60, 10);
                    default: dial_speed = $urandom_range(70000, 500);
                endcase
            end
            burst_left--;
            pick = $urandom_range(99);
            // now and then the sender waits for the result side to empty
            if ($urandom_range(99) == 0)
                drain();
            if (pick < 25) begin
                // tick with a random, ignored position field
                send_item(OP_TICK, $urandom());
            end else if (pick < 88) begin
                jitter = $urandom_range(2);
                dial   = dial + dial_dir * dial_speed + jitter - 1;
                send_item(OP_POSITION, dial);
            end else if (pick < 94) begin
                // glitch: a wild count, the knob carries on from where it was
                send_item(OP_POSITION, $urandom());
            end else begin
                send_item(OP_POSITION, dial);
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed part on the reset settings: 0 .. 10000, ratio 5, gap 10
        send_item(OP_TICK, '0);                 // tick before any movement
        send_item(OP_POSITION, '1);             // same count as after reset
        send_item(OP_POSITION, 32'd0);
        send_item(OP_POSITION, 32'd10);
        send_item(OP_TICK, '1);                 // fast turn, step goes up
        send_item(OP_POSITION, 32'd30);
        send_item(OP_TICK, '0);
        send_item(OP_POSITION, 32'd29);
        send_item(OP_TICK, '0);
        send_item(OP_TICK, '0);                 // no movement, step comes down
        send_item(OP_POSITION, 32'h7FFF_FFFF);  // hits the upper bound
        send_item(OP_POSITION, 32'h8000_0000);  // hits the lower bound
        send_item(OP_POSITION, 32'h8000_0000);  // unchanged count

        // full range, largest ratio, gap one: saturation of the sum
        drain();
        apply_settings(32'h8000_0000, 32'h7FFF_FFFF, 8'd255, 16'd1);
        send_item(OP_POSITION, 32'h7FFF_FFFF);
        send_item(OP_TICK, '0);
        send_item(OP_POSITION, 32'h8000_0000);
        send_item(OP_TICK, '0);

        // bounds crossed over, ratio zero, gap zero
        drain();
        apply_settings(32'd300, -32'sd300, 8'd0, 16'd0);
        send_item(OP_POSITION, 32'd0);
        send_item(OP_TICK, '0);
        send_item(OP_TICK, '0);

        // upper bound below one, ratio one
        drain();
        apply_settings(-32'sd1000, 32'd0, 8'd1, 16'd0);
        send_item(OP_POSITION, 32'd5);
        send_item(OP_TICK, '0);
        send_item(OP_POSITION, -32'sd300);
        send_item(OP_TICK, '0);

        // random phases, each on its own settings, in three pacing modes
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            drain();
            if (phase < 3) begin
                tx_idle_pct = 26;
                rx_idle_pct = 82;
            end else if (phase < 5) begin
                tx_idle_pct = 82;
                rx_idle_pct = 26;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            case (phase)
                0: apply_settings(32'd0, 32'd10000, 8'd5, 16'd10);
                1: apply_settings(-32'sd1000000, 32'd1000000, 8'd2, 16'd3);
                2: apply_settings(32'h8000_0000, 32'h7FFF_FFFF, 8'd255, 16'd1);
                3: apply_settings(32'h8000_0000, 32'h7FFF_FFFF, 8'd4, 16'hFFFF);
                4: apply_settings(32'd200, -32'sd200, 8'd0, 16'd0);
                5: apply_settings(-32'sd100000, 32'd0, 8'd1, 16'd2);
                default: apply_settings(-$urandom_range(1000000), $urandom_range(1000000, 1),
                                        RATIO_W'($urandom_range(255, 2)),
                                        GAP_W'($urandom_range(64, 1)));
            endcase
            run_random(ITEMS_PER_PHASE);
        end

        // let the last results out, then a margin for anything stray
        drain();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d encoder items (%0d ticks, %0d position samples) over %0d settings",
                 items_sent, ticks_sent, items_sent - ticks_sent, settings_used);
        $display("pacing: receiver-starved, sender-starved and back-to-back phases");
        if (fail_count == 0 && pending_results == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // watchdog: ends the run when no channel moves for too long
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

endmodule
